/* hdl/cssc_pkg.sv */
// Shared types, character codes and helpers for the C source style scanner.
`default_nettype none

package cssc_pkg;

	// Default sizes handed to the top level
	localparam int unsigned     STACK_DEPTH_DEF    = 64;
	localparam longint unsigned MAX_FILE_BYTES_DEF = 64'd16777215;

	// Counter width and saturation value
	localparam int unsigned CNT_W   = 24;
	localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

	// Character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Leading indent kinds
	localparam logic [1:0] IND_NONE  = 2'b00;
	localparam logic [1:0] IND_TAB   = 2'b01;
	localparam logic [1:0] IND_SPACE = 2'b10;
	localparam logic [1:0] IND_MIXED = 2'b11;

	// Statistics counter slots
	localparam int unsigned NUM_STATS = 10;
	typedef enum logic [3:0] {
		ST_END,
		ST_OWN,
		ST_INL,
		ST_TAB,
		ST_SPA,
		ST_MIX,
		ST_BLANK,
		ST_WS,
		ST_SPACED,
		ST_TIGHT
	} stat_idx_t;

	// Sequencer phases
	typedef enum logic [1:0] {
		PH_RUN,
		PH_FLUSH,
		PH_DRAIN
	} phase_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic [23:0] brace_at_line_end;
		logic [23:0] brace_on_own_line;
		logic [23:0] brace_pair_inline;
		logic [23:0] tab_indented_lines;
		logic [23:0] space_indented_lines;
		logic [23:0] mixed_indented_lines;
		logic [23:0] blank_lines;
		logic [23:0] whitespace_only_lines;
		logic [23:0] spaced_round_brackets;
		logic [23:0] tight_round_brackets;
		logic [23:0] line_total;
		logic [23:0] byte_total;
	} out_item_t;

	function automatic logic [23:0] sat_inc(input logic [23:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + 24'd1;
	endfunction

	function automatic logic [23:0] sat_dec(input logic [23:0] v);
		sat_dec = (v == 24'd0) ? v : v - 24'd1;
	endfunction

endpackage

`default_nettype wire

/* hdl/c_source_style_scanner_top.sv */
// C source style scanner: byte scanner, brace stack memory and statistics output.
`default_nettype none

// Takes one byte of a C source file per cycle while in PH_RUN and returns one
// statistics transaction per file, after the byte marked end_of_file. Ordinary
// bytes are accepted back to back. After the final byte is accepted, PH_FLUSH
// scans the held-back last byte against a zero and PH_DRAIN lets the brace stack
// read of that scan settle; PH_DRAIN also waits for the output register to be
// free, and no byte is taken in either phase. Open braces live in a synchronous
// memory of STACK_DEPTH entries with a registered read; a closing brace reads its
// entry in the scan cycle and the same-line check and count update happen in the
// cycle after. Bytes beyond MAX_FILE_BYTES are accepted but ignored.
// All counters saturate at 16777215.
module c_source_style_scanner_top #(
	parameter int unsigned     STACK_DEPTH    = cssc_pkg::STACK_DEPTH_DEF,
	parameter longint unsigned MAX_FILE_BYTES = cssc_pkg::MAX_FILE_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire cssc_pkg::in_item_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output cssc_pkg::out_item_t     out_data
);

	localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned BW = $clog2(MAX_FILE_BYTES + 64'd1);

	// Sequencer and control state
	cssc_pkg::phase_t phase_q, phase_d;
	logic             held_valid_q, held_valid_d;
	logic [7:0]       held_q, held_d;
	logic [7:0]       prev_q, prev_d;
	logic             skip_q, skip_d;
	logic             comment_q, comment_d;
	logic             weak_q, weak_d;
	logic             string_q, string_d;
	logic             code_q, code_d;
	logic [1:0]       indent_q, indent_d;
	logic [23:0]      line_q, line_d;
	logic [LW-1:0]    level_q, level_d;
	logic [BW-1:0]    bytes_q, bytes_d;
	logic [23:0]      stat_q [cssc_pkg::NUM_STATS];
	logic [23:0]      stat_d [cssc_pkg::NUM_STATS];

	// Second stage of a pop
	logic        pop_s2;
	logic [23:0] line_s2;
	logic [24:0] entry_s2;

	// Output register
	logic                out_valid_q;
	cssc_pkg::out_item_t out_q;

	// Brace stack memory: bit 24 is the code-before flag, low bits the line
	logic [24:0] stack_mem [STACK_DEPTH];

	logic                         in_fire, take_byte, scan_en, flush_scan, snap;
	logic [7:0]                   cur, nxt;
	logic                         quoted;
	logic                         push_en, pop_en;
	logic [AW-1:0]                push_addr, pop_addr;
	logic [24:0]                  push_entry;
	logic [cssc_pkg::NUM_STATS-1:0] bump_vec, drop_vec;
	logic                         inline_hit;
	logic [63:0]                  bytes_ext;

	assign in_fire   = in_valid && in_ready;
	assign take_byte = (64'(bytes_q) < MAX_FILE_BYTES);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			cssc_pkg::PH_RUN: begin
				if (in_fire && in_data.end_of_file) begin
					phase_d = cssc_pkg::PH_FLUSH;
				end
			end
			cssc_pkg::PH_FLUSH: begin
				phase_d = cssc_pkg::PH_DRAIN;
			end
			cssc_pkg::PH_DRAIN: begin
				if (!out_valid_q || out_ready) begin
					phase_d = cssc_pkg::PH_RUN;
				end
			end
			default: begin
				phase_d = cssc_pkg::PH_RUN;
			end
		endcase
	end

	// Phase outputs
	always_comb begin
		in_ready   = 1'b0;
		flush_scan = 1'b0;
		snap       = 1'b0;
		case (phase_q)
			cssc_pkg::PH_RUN: begin
				in_ready = 1'b1;
			end
			cssc_pkg::PH_FLUSH: begin
				flush_scan = 1'b1;
			end
			cssc_pkg::PH_DRAIN: begin
				snap = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Pick the byte pair to judge this cycle
	assign scan_en = held_valid_q && ((in_fire && take_byte) || flush_scan);
	assign cur     = held_q;
	assign nxt     = flush_scan ? cssc_pkg::CH_NUL : in_data.text_byte;
	assign quoted  = (prev_q == cssc_pkg::CH_SQUOTE) && (nxt == cssc_pkg::CH_SQUOTE);

	// Hold back the newest byte and count it
	always_comb begin
		held_d       = held_q;
		held_valid_d = held_valid_q;
		bytes_d      = bytes_q;
		if (in_fire && take_byte) begin
			held_d       = in_data.text_byte;
			held_valid_d = 1'b1;
			bytes_d      = bytes_q + BW'(1);
		end
	end

	// Scan one character against its neighbors
	always_comb begin
		prev_d     = prev_q;
		skip_d     = skip_q;
		comment_d  = comment_q;
		weak_d     = weak_q;
		string_d   = string_q;
		code_d     = code_q;
		indent_d   = indent_q;
		line_d     = line_q;
		level_d    = level_q;
		bump_vec   = '0;
		push_en    = 1'b0;
		pop_en     = 1'b0;
		push_addr  = level_q[AW-1:0];
		pop_addr   = AW'(level_q - LW'(1));
		push_entry = {code_q, line_q};
		if (scan_en) begin
			prev_d = cur;
			if (skip_q) begin
				skip_d = 1'b0;
			end else if (!code_q && (cur inside {cssc_pkg::CH_TAB, cssc_pkg::CH_SP})) begin
				indent_d = indent_q | ((cur == cssc_pkg::CH_TAB) ?
					cssc_pkg::IND_TAB : cssc_pkg::IND_SPACE);
			end else if (cur == cssc_pkg::CH_CR) begin
				prev_d = cur;
			end else if (cur == cssc_pkg::CH_LF) begin
				bump_vec[cssc_pkg::ST_TAB]   = (indent_q == cssc_pkg::IND_TAB);
				bump_vec[cssc_pkg::ST_SPA]   = (indent_q == cssc_pkg::IND_SPACE);
				bump_vec[cssc_pkg::ST_MIX]   = (indent_q == cssc_pkg::IND_MIXED);
				bump_vec[cssc_pkg::ST_BLANK] = !code_q && (indent_q == cssc_pkg::IND_NONE);
				bump_vec[cssc_pkg::ST_WS]    = !code_q && (indent_q != cssc_pkg::IND_NONE);
				if (weak_q) begin
					weak_d    = 1'b0;
					comment_d = 1'b0;
				end
				line_d   = cssc_pkg::sat_inc(line_q);
				indent_d = cssc_pkg::IND_NONE;
				code_d   = 1'b0;
				string_d = 1'b0;
			end else if (cur == cssc_pkg::CH_SLASH && nxt == cssc_pkg::CH_STAR
					&& !comment_q && !string_q) begin
				comment_d = 1'b1;
				code_d    = 1'b1;
			end else if (cur == cssc_pkg::CH_SLASH && nxt == cssc_pkg::CH_SLASH
					&& !comment_q && !string_q) begin
				comment_d = 1'b1;
				weak_d    = 1'b1;
				code_d    = 1'b1;
			end else if (prev_q == cssc_pkg::CH_STAR && cur == cssc_pkg::CH_SLASH
					&& comment_q && !string_q) begin
				comment_d = 1'b0;
				code_d    = 1'b1;
			end else if (cur == cssc_pkg::CH_HASH && !code_q && !comment_q && !string_q) begin
				comment_d = 1'b1;
				weak_d    = 1'b1;
				code_d    = 1'b1;
			end else if (cur == cssc_pkg::CH_LBRACE && !string_q && !comment_q && !quoted) begin
				bump_vec[cssc_pkg::ST_END] = code_q;
				bump_vec[cssc_pkg::ST_OWN] = !code_q;
				if (level_q < LW'(STACK_DEPTH)) begin
					push_en = 1'b1;
					level_d = level_q + LW'(1);
				end
				code_d = 1'b1;
			end else if (cur == cssc_pkg::CH_RBRACE && !string_q && !comment_q && !quoted) begin
				if (level_q != '0) begin
					pop_en  = 1'b1;
					level_d = level_q - LW'(1);
				end
				code_d = 1'b1;
			end else if (cur == cssc_pkg::CH_LPAREN && !comment_q && !string_q) begin
				if (nxt inside {cssc_pkg::CH_SP, cssc_pkg::CH_TAB}) begin
					bump_vec[cssc_pkg::ST_SPACED] = 1'b1;
				end else begin
					bump_vec[cssc_pkg::ST_TIGHT] = 1'b1;
				end
			end else if (cur == cssc_pkg::CH_RPAREN && !comment_q && !string_q) begin
				if (prev_q inside {cssc_pkg::CH_SP, cssc_pkg::CH_TAB}) begin
					bump_vec[cssc_pkg::ST_SPACED] = 1'b1;
				end else begin
					bump_vec[cssc_pkg::ST_TIGHT] = 1'b1;
				end
			end else if (cur == cssc_pkg::CH_BSLASH && string_q && !comment_q) begin
				skip_d = 1'b1;
			end else if (cur == cssc_pkg::CH_BSLASH && nxt == cssc_pkg::CH_LF) begin
				skip_d = 1'b1;
				line_d = cssc_pkg::sat_inc(line_q);
			end else if (cur == cssc_pkg::CH_DQUOTE && !comment_q && !quoted) begin
				string_d = !string_q;
				code_d   = 1'b1;
			end else begin
				code_d = 1'b1;
			end
		end
	end

	// Judge a popped brace against the line it closed on
	assign inline_hit = pop_s2 && (entry_s2[23:0] == line_s2);
	always_comb begin
		drop_vec = '0;
		drop_vec[cssc_pkg::ST_END] = inline_hit && entry_s2[24];
		drop_vec[cssc_pkg::ST_OWN] = inline_hit && !entry_s2[24];
	end

	// Apply the older pop first, then the current scan's increments
	always_comb begin
		logic [23:0] v;
		for (int i = 0; i < cssc_pkg::NUM_STATS; i++) begin
			v = stat_q[i];
			if (drop_vec[i]) begin
				v = cssc_pkg::sat_dec(v);
			end
			if (bump_vec[i] || (inline_hit && i == int'(cssc_pkg::ST_INL))) begin
				v = cssc_pkg::sat_inc(v);
			end
			stat_d[i] = v;
		end
	end

	// Brace stack memory: write on push, registered read on pop
	always_ff @(posedge clk) begin
		if (push_en) begin
			stack_mem[push_addr] <= push_entry;
		end
		if (pop_en) begin
			entry_s2 <= stack_mem[pop_addr];
			line_s2  <= line_q;
		end
	end

	// Control and counter registers; clear everything once the result is captured
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= cssc_pkg::PH_RUN;
			held_valid_q <= 1'b0;
			held_q       <= '0;
			prev_q       <= '0;
			skip_q       <= 1'b0;
			comment_q    <= 1'b0;
			weak_q       <= 1'b0;
			string_q     <= 1'b0;
			code_q       <= 1'b0;
			indent_q     <= cssc_pkg::IND_NONE;
			line_q       <= 24'd1;
			level_q      <= '0;
			bytes_q      <= '0;
			pop_s2       <= 1'b0;
			for (int i = 0; i < cssc_pkg::NUM_STATS; i++) begin
				stat_q[i] <= '0;
			end
		end else begin
			phase_q <= phase_d;
			if (snap) begin
				held_valid_q <= 1'b0;
				held_q       <= '0;
				prev_q       <= '0;
				skip_q       <= 1'b0;
				comment_q    <= 1'b0;
				weak_q       <= 1'b0;
				string_q     <= 1'b0;
				code_q       <= 1'b0;
				indent_q     <= cssc_pkg::IND_NONE;
				line_q       <= 24'd1;
				level_q      <= '0;
				bytes_q      <= '0;
				pop_s2       <= 1'b0;
				for (int i = 0; i < cssc_pkg::NUM_STATS; i++) begin
					stat_q[i] <= '0;
				end
			end else begin
				held_valid_q <= held_valid_d;
				held_q       <= held_d;
				prev_q       <= prev_d;
				skip_q       <= skip_d;
				comment_q    <= comment_d;
				weak_q       <= weak_d;
				string_q     <= string_d;
				code_q       <= code_d;
				indent_q     <= indent_d;
				line_q       <= line_d;
				level_q      <= level_d;
				bytes_q      <= bytes_d;
				pop_s2       <= pop_en;
				for (int i = 0; i < cssc_pkg::NUM_STATS; i++) begin
					stat_q[i] <= stat_d[i];
				end
			end
		end
	end

	// Output transaction valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (snap) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the statistics of the finished file
	assign bytes_ext = 64'(bytes_q);
	always_ff @(posedge clk) begin
		if (snap) begin
			out_q.brace_at_line_end     <= stat_d[cssc_pkg::ST_END];
			out_q.brace_on_own_line     <= stat_d[cssc_pkg::ST_OWN];
			out_q.brace_pair_inline     <= stat_d[cssc_pkg::ST_INL];
			out_q.tab_indented_lines    <= stat_d[cssc_pkg::ST_TAB];
			out_q.space_indented_lines  <= stat_d[cssc_pkg::ST_SPA];
			out_q.mixed_indented_lines  <= stat_d[cssc_pkg::ST_MIX];
			out_q.blank_lines           <= stat_d[cssc_pkg::ST_BLANK];
			out_q.whitespace_only_lines <= stat_d[cssc_pkg::ST_WS];
			out_q.spaced_round_brackets <= stat_d[cssc_pkg::ST_SPACED];
			out_q.tight_round_brackets  <= stat_d[cssc_pkg::ST_TIGHT];
			out_q.line_total            <= line_q;
			out_q.byte_total            <= (bytes_ext > 64'(cssc_pkg::CNT_MAX)) ?
				cssc_pkg::CNT_MAX : bytes_ext[23:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

/* sim/tb_c_source_style_scanner_top.sv */
// Testbench for the C source style scanner: byte stimulus, style prediction, result checks.
`timescale 1ns / 100ps

module tb_c_source_style_scanner_top;
	import cssc_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int NUM_FIELDS = 12;
	localparam int OUT_W      = $bits(out_item_t);
	localparam int RANDOM_BYTES = 1000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	// Bytes waiting to be sent and file statistics waiting to come back
	in_item_t  byte_q [$];
	out_item_t stats_q [$];
	int        item_total = 0;
	int        taken_cnt = 0;
	int        fail_cnt = 0;

	// Body of the file being built
	logic [7:0] file_body [$];

	// Idle percentages per traffic phase: sender, then receiver
	int send_idle_pct  [3] = '{16, 84, 0};
	int recv_stall_pct [3] = '{84, 16, 0};

	string field_name [NUM_FIELDS] = '{
		"brace_at_line_end", "brace_on_own_line", "brace_pair_inline",
		"tab_indented_lines", "space_indented_lines", "mixed_indented_lines",
		"blank_lines", "whitespace_only_lines", "spaced_round_brackets",
		"tight_round_brackets", "line_total", "byte_total"};

	// Scanner state as predicted
	logic [7:0]      held_char;
	logic            held_ok;
	logic [7:0]      prev_char;
	logic            skip_next;
	logic            in_comment;
	logic            in_line_comment;
	logic            in_string;
	logic            code_seen;
	logic [1:0]      indent_bits;
	logic [23:0]     line_no;
	logic [24:0]     brace_mem [STACK_DEPTH_DEF];
	int unsigned     brace_depth;
	logic [23:0]     tally [NUM_STATS];
	longint unsigned bytes_seen;

	c_source_style_scanner_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [23:0] count_up(input logic [23:0] v);
		return (v == CNT_MAX) ? v : v + 24'd1;
	endfunction

	function automatic logic [23:0] count_down(input logic [23:0] v);
		return (v == 24'd0) ? v : v - 24'd1;
	endfunction

	function automatic int idle_phase();
		int ph;
		ph = (item_total == 0) ? 0 : (taken_cnt * 3) / item_total;
		return (ph > 2) ? 2 : ph;
	endfunction

	task automatic clear_file_state();
		held_char       = 8'h00;
		held_ok         = 1'b0;
		prev_char       = 8'h00;
		skip_next       = 1'b0;
		in_comment      = 1'b0;
		in_line_comment = 1'b0;
		in_string       = 1'b0;
		code_seen       = 1'b0;
		indent_bits     = IND_NONE;
		line_no         = 24'd1;
		brace_depth     = 0;
		bytes_seen      = 0;
		for (int k = 0; k < NUM_STATS; k++)
			tally[k] = 24'd0;
	endtask

	// Judge one character with its neighbors
	task automatic scan_char(input logic [7:0] cur, input logic [7:0] nxt);
		logic [7:0]  prv;
		logic        cmt;
		logic        str;
		logic        code;
		logic        quoted;
		logic [24:0] entry;
		prv    = prev_char;
		cmt    = in_comment;
		str    = in_string;
		code   = code_seen;
		quoted = (prv == CH_SQUOTE) && (nxt == CH_SQUOTE);
		prev_char = cur;
		if (skip_next) begin
			skip_next = 1'b0;
			return;
		end

		if (!code && (cur == CH_TAB || cur == CH_SP)) begin
			indent_bits |= (cur == CH_TAB) ? IND_TAB : IND_SPACE;
		end else if (cur == CH_CR) begin
			// carriage return changes nothing
		end else if (cur == CH_LF) begin
			if (indent_bits == IND_TAB)   tally[ST_TAB] = count_up(tally[ST_TAB]);
			if (indent_bits == IND_SPACE) tally[ST_SPA] = count_up(tally[ST_SPA]);
			if (indent_bits == IND_MIXED) tally[ST_MIX] = count_up(tally[ST_MIX]);
			if (!code && indent_bits == IND_NONE) tally[ST_BLANK] = count_up(tally[ST_BLANK]);
			if (!code && indent_bits != IND_NONE) tally[ST_WS] = count_up(tally[ST_WS]);
			if (in_line_comment) begin
				in_line_comment = 1'b0;
				in_comment      = 1'b0;
			end
			line_no     = count_up(line_no);
			indent_bits = IND_NONE;
			code_seen   = 1'b0;
			in_string   = 1'b0;
		end else if (cur == CH_SLASH && nxt == CH_STAR && !cmt && !str) begin
			in_comment = 1'b1;
			code_seen  = 1'b1;
		end else if (cur == CH_SLASH && nxt == CH_SLASH && !cmt && !str) begin
			in_comment      = 1'b1;
			in_line_comment = 1'b1;
			code_seen       = 1'b1;
		end else if (prv == CH_STAR && cur == CH_SLASH && cmt && !str) begin
			in_comment = 1'b0;
			code_seen  = 1'b1;
		end else if (cur == CH_HASH && !code && !cmt && !str) begin
			// preprocessor line runs like a line comment
			in_comment      = 1'b1;
			in_line_comment = 1'b1;
			code_seen       = 1'b1;
		end else if (cur == CH_LBRACE && !str && !cmt && !quoted) begin
			if (code) tally[ST_END] = count_up(tally[ST_END]);
			else      tally[ST_OWN] = count_up(tally[ST_OWN]);
			// drop the entry when the stack is full
			if (brace_depth < STACK_DEPTH_DEF) begin
				brace_mem[brace_depth] = {code, line_no};
				brace_depth++;
			end
			code_seen = 1'b1;
		end else if (cur == CH_RBRACE && !str && !cmt && !quoted) begin
			if (brace_depth > 0) begin
				brace_depth--;
				entry = brace_mem[brace_depth];
				if (entry[23:0] == line_no) begin
					tally[ST_INL] = count_up(tally[ST_INL]);
					if (entry[24]) tally[ST_END] = count_down(tally[ST_END]);
					else           tally[ST_OWN] = count_down(tally[ST_OWN]);
				end
			end
			code_seen = 1'b1;
		end else if (cur == CH_LPAREN && !cmt && !str) begin
			if (nxt == CH_SP || nxt == CH_TAB) tally[ST_SPACED] = count_up(tally[ST_SPACED]);
			else                              tally[ST_TIGHT]  = count_up(tally[ST_TIGHT]);
		end else if (cur == CH_RPAREN && !cmt && !str) begin
			if (prv == CH_SP || prv == CH_TAB) tally[ST_SPACED] = count_up(tally[ST_SPACED]);
			else                              tally[ST_TIGHT]  = count_up(tally[ST_TIGHT]);
		end else if (cur == CH_BSLASH && str && !cmt) begin
			skip_next = 1'b1;
		end else if (cur == CH_BSLASH && nxt == CH_LF) begin
			skip_next = 1'b1;
			line_no   = count_up(line_no);
		end else if (cur == CH_DQUOTE && !cmt && !quoted) begin
			in_string = ~in_string;
			code_seen = 1'b1;
		end else begin
			code_seen = 1'b1;
		end
	endtask

	// Advance the prediction by one accepted byte; queue statistics at end of file
	task automatic take_byte(input in_item_t it);
		out_item_t res;
		if (bytes_seen < MAX_FILE_BYTES_DEF) begin
			bytes_seen++;
			if (held_ok)
				scan_char(held_char, it.text_byte);
			held_char = it.text_byte;
			held_ok   = 1'b1;
		end
		if (it.end_of_file) begin
			if (held_ok)
				scan_char(held_char, 8'h00);
			res.brace_at_line_end     = tally[ST_END];
			res.brace_on_own_line     = tally[ST_OWN];
			res.brace_pair_inline     = tally[ST_INL];
			res.tab_indented_lines    = tally[ST_TAB];
			res.space_indented_lines  = tally[ST_SPA];
			res.mixed_indented_lines  = tally[ST_MIX];
			res.blank_lines           = tally[ST_BLANK];
			res.whitespace_only_lines = tally[ST_WS];
			res.spaced_round_brackets = tally[ST_SPACED];
			res.tight_round_brackets  = tally[ST_TIGHT];
			res.line_total            = line_no;
			res.byte_total            = (bytes_seen > CNT_MAX) ? CNT_MAX : bytes_seen[23:0];
			stats_q.insert(stats_q.size(), res);
			clear_file_state();
		end
	endtask

	task automatic note_failure(input string msg);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("%0t ERROR: %s", $realtime, msg);
	endtask

	// Compare one statistics transaction with the oldest prediction
	task automatic check_stats(input out_item_t got);
		logic [OUT_W-1:0] gv;
		logic [OUT_W-1:0] wv;
		if (stats_q.size() == 0) begin
			note_failure("statistics transaction with none predicted");
			return;
		end
		gv = got;
		wv = stats_q.pop_front();
		for (int k = 0; k < NUM_FIELDS; k++) begin
			if (gv[OUT_W-1-24*k -: 24] !== wv[OUT_W-1-24*k -: 24])
				note_failure($sformatf("%s expected %0d got %0d", field_name[k],
					wv[OUT_W-1-24*k -: 24], gv[OUT_W-1-24*k -: 24]));
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic last);
		in_item_t it;
		it.text_byte   = b;
		it.end_of_file = last;
		byte_q.insert(byte_q.size(), it);
	endtask

	task automatic push_text(input string s);
		for (int k = 0; k < s.len(); k++)
			push_byte(s[k], k == s.len() - 1);
	endtask

	// Append one character to the file being built
	task automatic add_char(input logic [7:0] b);
		file_body.insert(file_body.size(), b);
	endtask

	// Queue the built file and start an empty one
	task automatic push_body();
		for (int k = 0; k < file_body.size(); k++)
			push_byte(file_body[k], k == file_body.size() - 1);
		file_body.delete();
	endtask

	function automatic logic [7:0] any_letter();
		return 8'h61 + 8'($urandom_range(25));
	endfunction

	// Build one file of C-like tokens with random content
	task automatic build_random_file(input int len);
		int n;
		while (file_body.size() < len) begin
			case ($urandom_range(19))
				0: add_char(CH_LF);
				1: begin
					add_char(CH_CR);
					add_char(CH_LF);
				end
				2: repeat ($urandom_range(1, 4))
					add_char($urandom_range(1) ? CH_TAB : CH_SP);
				3, 4: repeat ($urandom_range(1, 5)) add_char(any_letter());
				5: add_char(CH_LBRACE);
				6: add_char(CH_RBRACE);
				7: begin
					add_char(CH_LPAREN);
					if ($urandom_range(1)) add_char($urandom_range(1) ? CH_SP : CH_TAB);
				end
				8: begin
					if ($urandom_range(1)) add_char($urandom_range(1) ? CH_SP : CH_TAB);
					add_char(CH_RPAREN);
				end
				9: add_char(CH_SP);
				10: begin
					// string literal, sometimes with escapes
					add_char(CH_DQUOTE);
					n = $urandom_range(0, 4);
					repeat (n) begin
						case ($urandom_range(4))
							0: begin
								add_char(CH_BSLASH);
								add_char($urandom_range(1) ? CH_DQUOTE : CH_BSLASH);
							end
							1: add_char(CH_LBRACE);
							2: add_char(CH_LPAREN);
							default: add_char(any_letter());
						endcase
					end
					if ($urandom_range(7) != 0) add_char(CH_DQUOTE);
				end
				11: begin
					add_char(CH_SQUOTE);
					case ($urandom_range(2))
						0: add_char(CH_LBRACE);
						1: add_char(CH_RBRACE);
						default: add_char(CH_DQUOTE);
					endcase
					add_char(CH_SQUOTE);
				end
				12: begin
					add_char(CH_SLASH);
					add_char(CH_STAR);
					repeat ($urandom_range(0, 3))
						add_char($urandom_range(1) ? any_letter() : CH_RBRACE);
					if ($urandom_range(1)) add_char(CH_LF);
					add_char(CH_STAR);
					add_char(CH_SLASH);
				end
				13: begin
					add_char(CH_SLASH);
					add_char(CH_SLASH);
					repeat ($urandom_range(0, 3))
						add_char($urandom_range(1) ? any_letter() : CH_LPAREN);
				end
				14: begin
					add_char(CH_HASH);
					repeat ($urandom_range(1, 4)) add_char(any_letter());
				end
				15: begin
					add_char(CH_BSLASH);
					add_char(CH_LF);
				end
				16: begin
					add_char(CH_LBRACE);
					repeat ($urandom_range(0, 2)) add_char(any_letter());
					add_char(CH_RBRACE);
				end
				17: add_char(8'($urandom_range(255)));
				18: add_char(CH_STAR);
				default: add_char(CH_SLASH);
			endcase
		end
		push_body();
	endtask

	// Nest past the stack depth, then close more braces than were kept
	task automatic build_deep_file();
		repeat (STACK_DEPTH_DEF + 6) begin
			if ($urandom_range(3) == 0) add_char(CH_LF);
			if ($urandom_range(3) == 0) add_char(CH_TAB);
			add_char(CH_LBRACE);
		end
		repeat (STACK_DEPTH_DEF + 10) begin
			if ($urandom_range(3) == 0) add_char(CH_LF);
			add_char(CH_RBRACE);
		end
		push_body();
	endtask

	// Drive the byte channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else if (!in_valid || in_ready) begin
			if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct[idle_phase()]) begin
				in_valid <= 1'b1;
				in_data  <= byte_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Predict on each accepted byte, check each statistics transaction, stall the output
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				take_byte(in_data);
				taken_cnt <= taken_cnt + 1;
			end
			if (out_valid && out_ready)
				check_stats(out_data);
			out_ready <= ($urandom_range(99) >= recv_stall_pct[idle_phase()]);
		end
	end

	initial begin
		int random_bytes;
		int file_idx;
		clear_file_state();

		// Directed files: one-byte files, indentation styles, brace placement,
		// brackets, preprocessor, character literal, continuation, stray brace,
		// escape left pending at the end
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_text("\tf( a ){x}\n \t{\n\n");
		push_text("#a\n'{'x{\\\n}}");
		push_text("\"\\");

		// Random files, mostly short, a few deep ones
		random_bytes = 0;
		file_idx = 0;
		while (random_bytes < RANDOM_BYTES) begin
			int before_cnt;
			before_cnt = byte_q.size();
			if (file_idx % 25 == 7)
				build_deep_file();
			else if ($urandom_range(9) == 0)
				build_random_file($urandom_range(1, 4));
			else
				build_random_file($urandom_range(5, 40));
			random_bytes += byte_q.size() - before_cnt;
			file_idx++;
		end
		item_total = byte_q.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (taken_cnt == item_total);
		wait (stats_q.size() == 0);
		repeat (40) @(posedge clk);
		if (fail_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Stop a hung run
	initial begin
		#(2_000_000);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
